// ===== rtl/core/pcl_pkg.sv =====
// Shared types and constants of the positional character list.
`default_nettype none
package pcl_pkg;

    localparam int PCL_DEPTH = 32;
    localparam int POS_W     = 6;
    localparam int ELEM_W    = 8;
    localparam int STATUS_W  = 2;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_DUMP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BADPOS = 2'd1,
        STATUS_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_FROM_HEAD
    } t_cell_op;

    typedef enum logic [1:0] {
        CHAIN_IDLE,
        CHAIN_INSERT,
        CHAIN_DELETE,
        CHAIN_ROTATE
    } t_chain_kind;

    typedef struct packed {
        t_chain_kind        kind;
        logic [POS_W-1:0]   idx;
        logic [ELEM_W-1:0]  elem;
    } t_chain_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/pcl_if.sv =====
// Valid/ready channel interfaces for list requests and list results.
`default_nettype none
interface pcl_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [pcl_pkg::POS_W-1:0]  position;
    logic [pcl_pkg::ELEM_W-1:0] element;

    modport source (output valid, func, position, element, input ready);
    modport sink   (input valid, func, position, element, output ready);
endinterface

interface pcl_out_if;
    logic                         valid;
    logic                         ready;
    logic [pcl_pkg::ELEM_W-1:0]   item;
    logic [pcl_pkg::STATUS_W-1:0] status;
    logic                         end_marker;
    logic                         last;

    modport source (output valid, item, status, end_marker, last, input ready);
    modport sink   (input valid, item, status, end_marker, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pcl_cell.sv =====
// One storage cell of the list chain, holding a single byte.
`default_nettype none
module pcl_cell (
    input  wire logic                       i_clk,
    input  wire pcl_pkg::t_cell_op          i_op,
    input  wire logic [pcl_pkg::ELEM_W-1:0] i_left,
    input  wire logic [pcl_pkg::ELEM_W-1:0] i_right,
    input  wire logic [pcl_pkg::ELEM_W-1:0] i_head,
    input  wire logic [pcl_pkg::ELEM_W-1:0] i_elem,
    output logic [pcl_pkg::ELEM_W-1:0]      o_data
);

    logic [pcl_pkg::ELEM_W-1:0] r_data;
    logic [pcl_pkg::ELEM_W-1:0] n_data;

    always_comb begin
        case (i_op)
            pcl_pkg::CELL_LOAD:       n_data = i_elem;
            pcl_pkg::CELL_FROM_LEFT:  n_data = i_left;
            pcl_pkg::CELL_FROM_RIGHT: n_data = i_right;
            pcl_pkg::CELL_FROM_HEAD:  n_data = i_head;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/pcl_chain.sv =====
// Row of list cells with per-cell shift control and a rank read port.
`default_nettype none
module pcl_chain #(
    parameter int DEPTH = pcl_pkg::PCL_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire pcl_pkg::t_chain_cmd        i_cmd,
    input  wire logic [pcl_pkg::POS_W-1:0]  i_rd_idx,
    output logic [pcl_pkg::ELEM_W-1:0]      o_head,
    output logic [pcl_pkg::ELEM_W-1:0]      o_rd_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [pcl_pkg::ELEM_W-1:0] w_data [DEPTH];
    logic [IW-1:0]              w_idx;

    assign w_idx = i_cmd.idx[IW-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pcl_pkg::t_cell_op          w_op;
        logic [pcl_pkg::ELEM_W-1:0] w_left;
        logic [pcl_pkg::ELEM_W-1:0] w_right;

        assign w_left  = (g == 0) ? w_data[g] : w_data[(g == 0) ? 0 : g - 1];
        assign w_right = (g == DEPTH - 1) ? w_data[g]
                                          : w_data[(g == DEPTH - 1) ? g : g + 1];

        always_comb begin
            w_op = pcl_pkg::CELL_HOLD;
            case (i_cmd.kind)
                pcl_pkg::CHAIN_INSERT: begin
                    if (IW'(g) == w_idx) begin
                        w_op = pcl_pkg::CELL_LOAD;
                    end else if (IW'(g) > w_idx) begin
                        w_op = pcl_pkg::CELL_FROM_LEFT;
                    end
                end
                pcl_pkg::CHAIN_DELETE: begin
                    if (IW'(g) >= w_idx) begin
                        w_op = pcl_pkg::CELL_FROM_RIGHT;
                    end
                end
                pcl_pkg::CHAIN_ROTATE: begin
                    if (IW'(g) == w_idx) begin
                        w_op = pcl_pkg::CELL_FROM_HEAD;
                    end else if (IW'(g) < w_idx) begin
                        w_op = pcl_pkg::CELL_FROM_RIGHT;
                    end
                end
                default: w_op = pcl_pkg::CELL_HOLD;
            endcase
        end

        pcl_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .i_elem  (i_cmd.elem),
            .o_data  (w_data[g])
        );
    end

    assign o_head    = w_data[0];
    assign o_rd_data = w_data[i_rd_idx[IW-1:0]];

endmodule
`default_nettype wire

// ===== rtl/core/positional_char_list_top.sv =====
// Top level of the positional character list: control, status and result register.
//
//  Channel | Dir | Payload                            | Transfer
//  i_in    | in  | func, position, element            | valid && ready
//  o_out   | out | item, status, end_marker, last     | valid && ready
//
// Insert, delete and get each give one result from the output register.
// Dump gives one result per stored byte, then a closing end marker; the cell row rotates
// by one rank per byte and is back in order when the closing result is sent.
// No new request is taken during a dump or while the output register is held.
// Reset empties the list; stored bytes are not cleared.
`default_nettype none
module positional_char_list_top #(
    parameter int DEPTH = pcl_pkg::PCL_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pcl_in_if.sink      i_in,
    pcl_out_if.source   o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = pcl_pkg::POS_W + 1;

    pcl_pkg::t_state            r_state;
    pcl_pkg::t_state            n_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              n_idx;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [pcl_pkg::ELEM_W-1:0] r_item;
    logic [pcl_pkg::ELEM_W-1:0] n_item;
    pcl_pkg::t_status           r_status;
    pcl_pkg::t_status           n_status;
    logic                       r_end;
    logic                       n_end;
    logic                       r_last;
    logic                       n_last;

    logic                       w_in_fire;
    logic                       w_out_free;
    logic                       w_dump_emit;
    logic                       w_dump_elem;
    logic                       w_load;
    logic                       w_ins_bad;
    logic                       w_rd_bad;
    logic                       w_full;
    logic [PW-1:0]              w_pos;
    logic [PW-1:0]              w_cnt;
    logic [pcl_pkg::POS_W-1:0]  w_pos_m1;
    logic [pcl_pkg::ELEM_W-1:0] w_head;
    logic [pcl_pkg::ELEM_W-1:0] w_rd_data;
    pcl_pkg::t_chain_cmd        w_cmd;
    pcl_pkg::t_func             w_func;

    assign w_func     = pcl_pkg::t_func'(i_in.func);
    assign w_pos      = PW'(i_in.position);
    assign w_cnt      = PW'(r_count);
    assign w_pos_m1   = i_in.position - pcl_pkg::POS_W'(1);
    assign w_ins_bad  = (w_pos == '0) || (w_pos > w_cnt + PW'(1));
    assign w_rd_bad   = (w_pos == '0) || (w_pos > w_cnt);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    always_comb begin
        i_in.ready  = 1'b0;
        w_dump_emit = 1'b0;
        case (r_state)
            pcl_pkg::ST_IDLE: i_in.ready  = w_out_free;
            pcl_pkg::ST_DUMP: w_dump_emit = w_out_free;
            default: begin
                i_in.ready  = 1'b0;
                w_dump_emit = 1'b0;
            end
        endcase
    end

    assign w_dump_elem = w_dump_emit && (r_idx != r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcl_pkg::ST_IDLE: begin
                if (w_in_fire && (w_func == pcl_pkg::FUNC_DUMP)) begin
                    n_state = pcl_pkg::ST_DUMP;
                end
            end
            pcl_pkg::ST_DUMP: begin
                if (w_dump_emit && !w_dump_elem) begin
                    n_state = pcl_pkg::ST_IDLE;
                end
            end
            default: n_state = pcl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_cmd.kind = pcl_pkg::CHAIN_IDLE;
        w_cmd.idx  = w_pos_m1;
        w_cmd.elem = i_in.element;
        n_count    = r_count;
        n_idx      = r_idx;
        if (w_in_fire) begin
            case (w_func)
                pcl_pkg::FUNC_INSERT: begin
                    if (!w_ins_bad && !w_full) begin
                        w_cmd.kind = pcl_pkg::CHAIN_INSERT;
                        n_count    = r_count + CW'(1);
                    end
                end
                pcl_pkg::FUNC_DELETE: begin
                    if (!w_rd_bad) begin
                        w_cmd.kind = pcl_pkg::CHAIN_DELETE;
                        n_count    = r_count - CW'(1);
                    end
                end
                pcl_pkg::FUNC_DUMP: n_idx = '0;
                default: n_idx = r_idx;
            endcase
        end else if (w_dump_elem) begin
            w_cmd.kind = pcl_pkg::CHAIN_ROTATE;
            w_cmd.idx  = pcl_pkg::POS_W'(r_count - CW'(1));
            n_idx      = r_idx + CW'(1);
        end
    end

    always_comb begin
        w_load   = 1'b0;
        n_item   = '0;
        n_status = pcl_pkg::STATUS_OK;
        n_end    = 1'b0;
        n_last   = 1'b1;
        if (w_in_fire) begin
            case (w_func)
                pcl_pkg::FUNC_INSERT: begin
                    w_load = 1'b1;
                    if (w_ins_bad) begin
                        n_status = pcl_pkg::STATUS_BADPOS;
                    end else if (w_full) begin
                        n_status = pcl_pkg::STATUS_FULL;
                    end
                end
                pcl_pkg::FUNC_DELETE: begin
                    w_load = 1'b1;
                    if (w_rd_bad) begin
                        n_status = pcl_pkg::STATUS_BADPOS;
                    end
                end
                pcl_pkg::FUNC_GET: begin
                    w_load = 1'b1;
                    if (w_rd_bad) begin
                        n_status = pcl_pkg::STATUS_BADPOS;
                    end else begin
                        n_item = w_rd_data;
                    end
                end
                default: w_load = 1'b0;
            endcase
        end else if (w_dump_emit) begin
            w_load = 1'b1;
            if (w_dump_elem) begin
                n_item = w_head;
                n_last = 1'b0;
            end else begin
                n_end = 1'b1;
            end
        end
        n_out_valid = w_load ? 1'b1 : (r_out_valid && !o_out.ready);
    end

    pcl_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_rd_idx  (w_pos_m1),
        .o_head    (w_head),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcl_pkg::ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item   <= n_item;
            r_status <= n_status;
            r_end    <= n_end;
            r_last   <= n_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.item       = r_item;
    assign o_out.status     = r_status;
    assign o_out.end_marker = r_end;
    assign o_out.last       = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("List count exceeds the depth.");

    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcl_pkg::ST_DUMP) |-> !i_in.ready)
        else $error("Request accepted during a dump.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_func != pcl_pkg::FUNC_DUMP)) |=> (r_out_valid && r_last))
        else $error("Single-result request did not load a final result.");

    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcl_pkg::ST_DUMP) |-> (r_idx <= r_count))
        else $error("Dump index ran past the list count.");

endmodule
`default_nettype wire
